### rtl/msph_pkg.sv
// Shared types and codes for the sustain pedal hold block.
// Request and response word layouts, event codes, result limit.
// No dependencies.
`default_nettype none

package msph_pkg;

   localparam logic [1:0] FUNC_PRESS    = 2'd0;
   localparam logic [1:0] FUNC_RELEASE  = 2'd1;
   localparam logic [1:0] FUNC_NOTE_ON  = 2'd2;
   localparam logic [1:0] FUNC_NOTE_OFF = 2'd3;

   localparam int MAX_RESULTS = 4;

   typedef struct packed {
      logic [1:0] func;
      logic [3:0] chan;
      logic [6:0] note_num;
      logic [6:0] vel;
   } req_word_type;

   typedef struct packed {
      logic        is_note_on;
      logic [3:0]  out_chan;
      logic [6:0]  out_note;
      logic [6:0]  out_vel;
      logic [1:0]  note_group;
      logic [31:0] note_mask;
      logic        last;
   } rsp_word_type;

endpackage

`default_nettype wire

### rtl/msph_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module msph_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/msph_note_map.sv
// Splits a note number into its held-map word index and bit masks.
// No dependencies.
`default_nettype none

module msph_note_map #(
   parameter int WORD_BITS = 32
) (
   input  wire logic [6:0]           note,
   output logic      [3:0]           word,
   output logic      [WORD_BITS-1:0] word_mask,
   output logic      [31:0]          mask32
);

   localparam int QMAX = 127 / WORD_BITS;

   logic [5:0] offs;

   always_comb begin
      word = 4'd0;
      for (int k = 1; k < 16; k++) begin
         if (k <= QMAX && int'(note) >= k * WORD_BITS) begin
            word = 4'(k);
         end
      end
      offs      = 6'(note - 7'(int'(word) * WORD_BITS));
      word_mask = WORD_BITS'(64'd1 << offs);
      mask32    = 32'(64'd1 << offs);
   end

endmodule

`default_nettype wire

### rtl/msph_held_store.sv
// Held note-off map: RAM plus per-entry valid flags; unwritten entries read zero.
// Depends on msph_ram.
`default_nettype none

module msph_held_store #(
   parameter int ADDR_BITS = 6,
   parameter int WORD_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [ADDR_BITS-1:0] addr,
   input  wire logic                 rd_en,
   input  wire logic                 wr_en,
   input  wire logic [WORD_BITS-1:0] wr_data,
   input  wire logic                 clr_en,
   output logic      [WORD_BITS-1:0] rd_word
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DEPTH-1:0]     vld_ff;
   logic [DEPTH-1:0]     vld_in;
   logic                 rd_vld_ff;
   logic [WORD_BITS-1:0] ram_data;

   msph_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (ram_data)
   );

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[addr] = 1'b1;
      end else if (clr_en) begin
         vld_in[addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (rd_en) begin
            rd_vld_ff <= vld_ff[addr];
         end
      end
   end

   assign rd_word = rd_vld_ff ? ram_data : '0;

endmodule

`default_nettype wire

### rtl/midi_sustain_pedal_hold_core.sv
// Sustain pedal hold: one item at a time, RMW on the held-note RAM; uses msph_pkg, note_map, store.
// Press sets the pedal bit, no result. Tracked note on/off: read in decode, write in RMW,
// result registered in emit; held note off set in RMW, no result; untracked channel/note: emit.
// Release: a scan and a check state per word (NOTES/WORD_BITS words), then flush; a result
// stalled in the output register stops the block, and req with it, once the next is ready.
// Reset clears pedal bits and the held map at once through per-entry valid flags.
`default_nettype none

module midi_sustain_pedal_hold_core #(
   parameter int CHANNELS  = 16,
   parameter int NOTES     = 128,
   parameter int WORD_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire msph_pkg::req_word_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output msph_pkg::rsp_word_type     rsp_data
);

   import msph_pkg::*;

   localparam int WORDS = (NOTES + WORD_BITS - 1) / WORD_BITS;
   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int AW    = CW + WW;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_RMW    = 7'b0000100,
      S_EMIT   = 7'b0001000,
      S_SCAN   = 7'b0010000,
      S_SCHK   = 7'b0100000,
      S_FLUSH  = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   req_word_type         item_ff, item_in;
   logic [CHANNELS-1:0]  pedal_ff, pedal_in;
   logic [WW-1:0]        idx_ff, idx_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [WW-1:0]        pend_idx_ff, pend_idx_in;
   logic [31:0]          pend_mask_ff, pend_mask_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_ff, rsp_in;

   logic                 rsp_load;
   logic                 out_free;
   logic                 ch_ok, note_ok, pedal_hit;
   logic [3:0]           word;
   logic [WORD_BITS-1:0] word_mask;
   logic [31:0]          mask32;
   logic [AW-1:0]        st_addr;
   logic                 st_rd_en, st_wr_en, st_clr_en;
   logic [WORD_BITS-1:0] st_wr_data, st_rd_word;
   logic [CHANNELS-1:0]  chan_bit;
   rsp_word_type         pend_rsp;

   msph_note_map #(
      .WORD_BITS(WORD_BITS)
   ) u_note_map (
      .note      (item_ff.note_num),
      .word      (word),
      .word_mask (word_mask),
      .mask32    (mask32)
   );

   msph_held_store #(
      .ADDR_BITS(AW),
      .WORD_BITS(WORD_BITS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .addr    (st_addr),
      .rd_en   (st_rd_en),
      .wr_en   (st_wr_en),
      .wr_data (st_wr_data),
      .clr_en  (st_clr_en),
      .rd_word (st_rd_word)
   );

   assign ch_ok     = int'(item_ff.chan) < CHANNELS;
   assign note_ok   = int'(item_ff.note_num) < NOTES;
   assign chan_bit  = CHANNELS'(1) << item_ff.chan;
   assign pedal_hit = |(pedal_ff & chan_bit);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      pend_rsp.is_note_on = 1'b0;
      pend_rsp.out_chan   = item_ff.chan;
      pend_rsp.out_note   = 7'(int'(pend_idx_ff) * WORD_BITS);
      pend_rsp.out_vel    = 7'd0;
      pend_rsp.note_group = 2'(pend_idx_ff);
      pend_rsp.note_mask  = pend_mask_ff;
      pend_rsp.last       = 1'b0;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      pedal_in     = pedal_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      pend_vld_in  = pend_vld_ff;
      pend_idx_in  = pend_idx_ff;
      pend_mask_in = pend_mask_ff;
      rsp_load     = 1'b0;
      rsp_in       = rsp_ff;
      st_addr      = {item_ff.chan[CW-1:0], word[WW-1:0]};
      st_rd_en     = 1'b0;
      st_wr_en     = 1'b0;
      st_wr_data   = st_rd_word;
      st_clr_en    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            if (item_ff.func == FUNC_PRESS) begin
               pedal_in = pedal_ff | chan_bit;
            end else if (item_ff.func == FUNC_RELEASE) begin
               if (ch_ok) begin
                  pedal_in    = pedal_ff & ~chan_bit;
                  idx_in      = '0;
                  cnt_in      = 3'd0;
                  pend_vld_in = 1'b0;
                  state_in    = S_SCAN;
               end
            end else if (ch_ok && note_ok) begin
               st_rd_en = 1'b1;
               state_in = S_RMW;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_RMW: begin
            state_in = S_EMIT;
            if (item_ff.func == FUNC_NOTE_ON) begin
               st_wr_en   = 1'b1;
               st_wr_data = st_rd_word & ~word_mask;
            end else if (pedal_hit) begin
               st_wr_en   = 1'b1;
               st_wr_data = st_rd_word | word_mask;
               state_in   = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_load          = 1'b1;
               rsp_in.is_note_on = (item_ff.func == FUNC_NOTE_ON);
               rsp_in.out_chan   = item_ff.chan;
               rsp_in.out_note   = item_ff.note_num;
               rsp_in.out_vel    = (item_ff.func == FUNC_NOTE_ON) ? item_ff.vel : 7'd0;
               rsp_in.note_group = word[1:0];
               rsp_in.note_mask  = (item_ff.func == FUNC_NOTE_ON) ? 32'd0 : mask32;
               rsp_in.last       = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_SCAN: begin
            st_addr  = {item_ff.chan[CW-1:0], idx_ff};
            st_rd_en = 1'b1;
            state_in = S_SCHK;
         end
         S_SCHK: begin
            st_addr = {item_ff.chan[CW-1:0], idx_ff};
            if (|st_rd_word) begin
               if (!pend_vld_ff || out_free) begin
                  if (pend_vld_ff) begin
                     rsp_load = 1'b1;
                     rsp_in   = pend_rsp;
                  end
                  pend_vld_in  = 1'b1;
                  pend_idx_in  = idx_ff;
                  pend_mask_in = 32'(st_rd_word);
                  st_clr_en    = 1'b1;
                  cnt_in       = cnt_ff + 3'd1;
                  if (cnt_ff == 3'(MAX_RESULTS - 1) || int'(idx_ff) == WORDS - 1) begin
                     state_in = S_FLUSH;
                  end else begin
                     idx_in   = idx_ff + WW'(1);
                     state_in = S_SCAN;
                  end
               end
            end else if (int'(idx_ff) == WORDS - 1) begin
               state_in = S_FLUSH;
            end else begin
               idx_in   = idx_ff + WW'(1);
               state_in = S_SCAN;
            end
         end
         S_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_load      = 1'b1;
               rsp_in        = pend_rsp;
               rsp_in.last   = 1'b1;
               pend_vld_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pedal_ff     <= '0;
         idx_ff       <= '0;
         cnt_ff       <= 3'd0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pedal_ff     <= pedal_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      pend_idx_ff  <= pend_idx_in;
      pend_mask_ff <= pend_mask_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result loaded over an unaccepted word");

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(MAX_RESULTS))
      else $error("release result count overran");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_vld_ff)
      else $error("pending group left behind at idle");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECODE && item_ff.func == FUNC_RELEASE && ch_ok)
      |=> !(|(pedal_ff & chan_bit)))
      else $error("pedal bit not cleared on release");
`endif

endmodule

`default_nettype wire
